### design/aao_pkg.sv
`default_nettype none

package aao_pkg;

    // Default group sizes.
    localparam int unsigned SPG_DEFAULT = 10;
    localparam int unsigned GPO_DEFAULT = 10;

    // Port field widths.
    localparam int unsigned SAMPLE_W   = 10;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned MEAN_W     = 13;
    localparam int unsigned MAG_W      = 13;
    localparam int unsigned ORIENT_W   = 3;

    // Scaled acceleration in hundredths of g, and the running sums.
    localparam int unsigned G_W   = 13;
    localparam int unsigned SUM_W = 17;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X_MV      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y_MV      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z_MV      = 2'd3;

    // One completed group, handed from the front end to the back end.
    typedef struct packed {
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        logic signed [SUM_W-1:0] sum_z;
        logic signed [G_W-1:0]   g_x;
        logic signed [G_W-1:0]   g_y;
        logic signed [G_W-1:0]   g_z;
    } group_job_t;

endpackage

`default_nettype wire

### design/aao_if.sv
`default_nettype none

interface aao_sample_if
    import aao_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_x;
    logic [SAMPLE_W-1:0] sample_y;
    logic [SAMPLE_W-1:0] sample_z;

    modport source (output valid, output sample_x, output sample_y, output sample_z,
                    input ready);
    modport sink (input valid, input sample_x, input sample_y, input sample_z,
                  output ready);
endinterface

interface aao_result_if
    import aao_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [MEAN_W-1:0]   mean_x;
    logic signed [MEAN_W-1:0]   mean_y;
    logic signed [MEAN_W-1:0]   mean_z;
    logic [MAG_W-1:0]           magnitude;
    logic signed [ORIENT_W-1:0] orientation;
    logic                       orientation_fresh;

    modport source (output valid, output mean_x, output mean_y, output mean_z,
                    output magnitude, output orientation, output orientation_fresh,
                    input ready);
    modport sink (input valid, input mean_x, input mean_y, input mean_z,
                  input magnitude, input orientation, input orientation_fresh,
                  output ready);
endinterface

`default_nettype wire

### design/aao_front.sv
`default_nettype none

module aao_front
    import aao_pkg::*;
#(
    parameter int unsigned SAMPLES_PER_GROUP = SPG_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    aao_sample_if.sink            sample,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output logic                  push,
    output group_job_t            push_job,
    input  logic                  full
);

    localparam int unsigned IDX_W = (SAMPLES_PER_GROUP > 1) ? $clog2(SAMPLES_PER_GROUP) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES_PER_GROUP - 1);

    localparam int unsigned COUNT_W    = 12;
    localparam int unsigned V_W        = 13;
    localparam int unsigned CNT_PROD_W = 35;
    localparam int unsigned MV_SHIFT   = 23;
    // ceil(2^31 / 825): mv * 1024 / 3300 is (|mv| << 8) / 825, exact for |mv| <= 4096.
    localparam logic [CNT_PROD_W-1:0] MV_RECIP = CNT_PROD_W'(2603011);

    localparam int unsigned SCL_PROD_W  = 24;
    localparam int unsigned SCALE_SHIFT = 10;
    localparam logic signed [SCL_PROD_W-1:0] SCALE_SPAN_HI = 24'sd412;
    localparam logic signed [SCL_PROD_W-1:0] SCALE_SPAN_LO = 24'sd1625;
    localparam logic signed [SCL_PROD_W-1:0] ROUND_BIAS    = 24'sd1023;
    localparam logic signed [G_W:0]          SCALE_LOW_HI  = 14'sd206;
    localparam logic signed [G_W:0]          SCALE_LOW_LO  = 14'sd825;
    localparam logic signed [V_W-1:0]        XY_BIAS       = 13'sd2;

    function automatic logic signed [COUNT_W-1:0] mv_to_counts(
        input logic signed [CFG_DATA_W-1:0] mv
    );
        logic [CFG_DATA_W-1:0] mag;
        logic [CNT_PROD_W-1:0] prod;
        logic [COUNT_W-1:0]    q;
        mag  = mv[CFG_DATA_W-1] ? CFG_DATA_W'(-mv) : CFG_DATA_W'(mv);
        prod = CNT_PROD_W'(mag) * MV_RECIP;
        q    = COUNT_W'(prod >> MV_SHIFT);
        return mv[CFG_DATA_W-1] ? -$signed(q) : $signed(q);
    endfunction

    // Truncating linear map of 0..1024 counts onto the selected g range.
    function automatic logic signed [G_W-1:0] scale(
        input logic signed [V_W-1:0] v,
        input logic                  sens
    );
        logic signed [SCL_PROD_W-1:0] prod;
        logic signed [SCL_PROD_W-1:0] adj;
        logic signed [G_W:0]          t;
        prod = SCL_PROD_W'(v) * (sens ? SCALE_SPAN_HI : SCALE_SPAN_LO);
        adj  = prod[SCL_PROD_W-1] ? prod + ROUND_BIAS : prod;
        t    = (G_W+1)'(adj >>> SCALE_SHIFT);
        t    = t - (sens ? SCALE_LOW_HI : SCALE_LOW_LO);
        return G_W'(t);
    endfunction

    logic                      sens_reg, sens_next;
    logic signed [COUNT_W-1:0] cnt_reg [3];
    logic signed [COUNT_W-1:0] cnt_next [3];
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic                      s1_valid_reg, s1_valid_next;
    logic                      s1_last_reg, s1_last_next;
    logic signed [V_W-1:0]     v_reg [3];
    logic signed [V_W-1:0]     v_next [3];
    logic                      s2_valid_reg, s2_valid_next;
    logic                      s2_last_reg, s2_last_next;
    logic signed [G_W-1:0]     g_reg [3];
    logic signed [G_W-1:0]     g_next [3];
    logic signed [SUM_W-1:0]   sum_reg [3];
    logic signed [SUM_W-1:0]   sum_next [3];
    logic signed [SUM_W-1:0]   total [3];
    logic                      advance;
    logic                      accept;

    always_comb
    begin
        // The whole front stalls only when a finished group cannot enter the queue.
        advance = !(s2_valid_reg && s2_last_reg && full);
        accept  = sample.valid && advance;

        sens_next     = sens_reg;
        idx_next      = idx_reg;
        s1_valid_next = s1_valid_reg;
        s1_last_next  = s1_last_reg;
        s2_valid_next = s2_valid_reg;
        s2_last_next  = s2_last_reg;
        for (int k = 0; k < 3; k++)
        begin
            cnt_next[k] = cnt_reg[k];
            v_next[k]   = v_reg[k];
            g_next[k]   = g_reg[k];
            sum_next[k] = sum_reg[k];
            total[k]    = sum_reg[k] + SUM_W'(g_reg[k]);
        end

        if (wr_en)
        begin
            case (wr_index)
                CFG_SENSITIVITY_HIGH: sens_next   = wr_data[0];
                CFG_OFFSET_X_MV:      cnt_next[0] = mv_to_counts(wr_data);
                CFG_OFFSET_Y_MV:      cnt_next[1] = mv_to_counts(wr_data);
                CFG_OFFSET_Z_MV:      cnt_next[2] = mv_to_counts(wr_data);
                default:              sens_next   = sens_reg;
            endcase
        end

        if (accept)
        begin
            idx_next = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
        end

        if (advance)
        begin
            s1_valid_next = accept;
            s1_last_next  = (idx_reg == IDX_LAST);
            v_next[0] = V_W'($signed({1'b0, sample.sample_x})) + V_W'(cnt_reg[0]) + XY_BIAS;
            v_next[1] = V_W'($signed({1'b0, sample.sample_y})) + V_W'(cnt_reg[1]) + XY_BIAS;
            v_next[2] = V_W'($signed({1'b0, sample.sample_z})) + V_W'(cnt_reg[2]);

            s2_valid_next = s1_valid_reg;
            s2_last_next  = s1_last_reg;
            for (int k = 0; k < 3; k++)
            begin
                g_next[k] = scale(v_reg[k], sens_reg);
            end

            if (s2_valid_reg)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    sum_next[k] = s2_last_reg ? '0 : total[k];
                end
            end
        end
    end

    assign sample.ready   = advance;
    assign push           = s2_valid_reg && s2_last_reg && !full;
    assign push_job.sum_x = total[0];
    assign push_job.sum_y = total[1];
    assign push_job.sum_z = total[2];
    assign push_job.g_x   = g_reg[0];
    assign push_job.g_y   = g_reg[1];
    assign push_job.g_z   = g_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_reg     <= 1'b1;
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                cnt_reg[k] <= '0;
                sum_reg[k] <= '0;
            end
        end
        else
        begin
            sens_reg     <= sens_next;
            idx_reg      <= idx_next;
            s1_valid_reg <= s1_valid_next;
            s1_last_reg  <= s1_last_next;
            s2_valid_reg <= s2_valid_next;
            s2_last_reg  <= s2_last_next;
            for (int k = 0; k < 3; k++)
            begin
                cnt_reg[k] <= cnt_next[k];
                sum_reg[k] <= sum_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            v_reg[k] <= v_next[k];
            g_reg[k] <= g_next[k];
        end
    end

endmodule

`default_nettype wire

### design/aao_fifo.sv
`default_nettype none

module aao_fifo
    import aao_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  group_job_t push_job,
    output logic       full,
    input  logic       pop,
    output group_job_t pop_job,
    output logic       empty
);

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    group_job_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

### design/aao_back.sv
`default_nettype none

module aao_back
    import aao_pkg::*;
#(
    parameter int unsigned SAMPLES_PER_GROUP      = SPG_DEFAULT,
    parameter int unsigned GROUPS_PER_ORIENTATION = GPO_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       empty,
    output logic       pop,
    input  group_job_t pop_job,
    aao_result_if.source result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_MEAN,
        S_AVG_MUL,
        S_CLASS,
        S_SQRT,
        S_EMIT
    } state_t;

    localparam int unsigned GRP_W =
        (GROUPS_PER_ORIENTATION > 1) ? $clog2(GROUPS_PER_ORIENTATION) : 1;
    localparam logic [GRP_W-1:0] GRP_LAST = GRP_W'(GROUPS_PER_ORIENTATION - 1);

    // Truncating division by a constant: (|s| * ceil(2^k / d)) >> k is exact for
    // |s| < 2^SUM_W when k = SUM_W + ceil(log2(d)).
    localparam int unsigned MUL_W   = SUM_W + 2;
    localparam int unsigned PROD_W  = SUM_W + MUL_W;
    localparam int unsigned MEAN_SH = SUM_W + $clog2(SAMPLES_PER_GROUP);
    localparam int unsigned AVG_SH  = SUM_W + $clog2(GROUPS_PER_ORIENTATION);
    localparam logic [MUL_W-1:0] MEAN_MUL = MUL_W'(((64'd1 << MEAN_SH)
        + 64'(SAMPLES_PER_GROUP) - 64'd1) / 64'(SAMPLES_PER_GROUP));
    localparam logic [MUL_W-1:0] AVG_MUL = MUL_W'(((64'd1 << AVG_SH)
        + 64'(GROUPS_PER_ORIENTATION) - 64'd1) / 64'(GROUPS_PER_ORIENTATION));

    localparam int unsigned SQ_W  = 2 * G_W - 2;
    localparam int unsigned RAD_W = SQ_W + 2;
    localparam logic [RAD_W-1:0] ROOT_START = {2'b01, {(RAD_W-2){1'b0}}};

    localparam logic signed [G_W:0] ONE_G = 14'sd100;

    localparam logic signed [ORIENT_W-1:0] ORIENT_NONE  = 3'sd0;
    localparam logic signed [ORIENT_W-1:0] ORIENT_POS_X = 3'sd1;
    localparam logic signed [ORIENT_W-1:0] ORIENT_NEG_X = -3'sd1;
    localparam logic signed [ORIENT_W-1:0] ORIENT_POS_Y = 3'sd2;
    localparam logic signed [ORIENT_W-1:0] ORIENT_NEG_Y = -3'sd2;
    localparam logic signed [ORIENT_W-1:0] ORIENT_POS_Z = 3'sd3;
    localparam logic signed [ORIENT_W-1:0] ORIENT_NEG_Z = -3'sd3;

    function automatic logic [SUM_W-1:0] abs_sum(input logic signed [SUM_W-1:0] v);
        return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    endfunction

    // Distance of |a| from one g.
    function automatic logic [G_W:0] dist_one_g(input logic signed [G_W-1:0] a);
        logic signed [G_W:0] aw;
        logic signed [G_W:0] diff;
        aw   = (G_W+1)'(a);
        aw   = (aw < 0) ? -aw : aw;
        diff = ONE_G - aw;
        diff = (diff < 0) ? -diff : diff;
        return diff;
    endfunction

    state_t                     state_reg, state_next;
    group_job_t                 job_reg, job_next;
    logic [PROD_W-1:0]          prod_reg [3];
    logic [PROD_W-1:0]          prod_next [3];
    logic                       neg_reg [3];
    logic                       neg_next [3];
    logic [SQ_W-1:0]            sq_reg [3];
    logic [SQ_W-1:0]            sq_next [3];
    logic signed [G_W-1:0]      mean_reg [3];
    logic signed [G_W-1:0]      mean_next [3];
    logic signed [SUM_W-1:0]    msum_reg [3];
    logic signed [SUM_W-1:0]    msum_next [3];
    logic [GRP_W-1:0]           grp_reg, grp_next;
    logic signed [ORIENT_W-1:0] orient_reg, orient_next;
    logic                       fresh_reg, fresh_next;
    logic [RAD_W-1:0]           rad_reg, rad_next;
    logic [RAD_W-1:0]           root_reg, root_next;
    logic [RAD_W-1:0]           bit_reg, bit_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [MEAN_W-1:0]   out_mean_reg [3];
    logic signed [MEAN_W-1:0]   out_mean_next [3];
    logic [MAG_W-1:0]           out_mag_reg, out_mag_next;
    logic signed [ORIENT_W-1:0] out_orient_reg, out_orient_next;
    logic                       out_fresh_reg, out_fresh_next;

    logic signed [SUM_W-1:0]    sums [3];
    logic signed [G_W-1:0]      gs [3];
    logic signed [2*G_W-1:0]    gw [3];
    logic [G_W-1:0]             quot [3];
    logic signed [G_W-1:0]      avg [3];
    logic [G_W:0]               dev [3];
    logic [RAD_W-1:0]           trial;

    always_comb
    begin
        sums[0] = job_reg.sum_x;
        sums[1] = job_reg.sum_y;
        sums[2] = job_reg.sum_z;
        gs[0]   = job_reg.g_x;
        gs[1]   = job_reg.g_y;
        gs[2]   = job_reg.g_z;

        state_next      = state_reg;
        job_next        = job_reg;
        grp_next        = grp_reg;
        orient_next     = orient_reg;
        fresh_next      = fresh_reg;
        rad_next        = rad_reg;
        root_next       = root_reg;
        bit_next        = bit_reg;
        out_mag_next    = out_mag_reg;
        out_orient_next = out_orient_reg;
        out_fresh_next  = out_fresh_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        pop             = 1'b0;
        trial           = root_reg + bit_reg;
        for (int k = 0; k < 3; k++)
        begin
            prod_next[k]     = prod_reg[k];
            neg_next[k]      = neg_reg[k];
            sq_next[k]       = sq_reg[k];
            mean_next[k]     = mean_reg[k];
            msum_next[k]     = msum_reg[k];
            out_mean_next[k] = out_mean_reg[k];
            gw[k]            = (2*G_W)'(gs[k]);
            quot[k]          = G_W'(prod_reg[k] >> MEAN_SH);
            avg[k]           = G_W'(prod_reg[k] >> AVG_SH);
            avg[k]           = neg_reg[k] ? -avg[k] : avg[k];
            dev[k]           = dist_one_g(avg[k]);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    job_next   = pop_job;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    neg_next[k]  = sums[k][SUM_W-1];
                    prod_next[k] = PROD_W'(abs_sum(sums[k])) * PROD_W'(MEAN_MUL);
                    sq_next[k]   = SQ_W'(gw[k] * gw[k]);
                end
                state_next = S_MEAN;
            end
            S_MEAN:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    mean_next[k] = neg_reg[k] ? -$signed(quot[k]) : $signed(quot[k]);
                    msum_next[k] = msum_reg[k] + SUM_W'(mean_next[k]);
                end
                rad_next  = RAD_W'(sq_reg[0]) + RAD_W'(sq_reg[1]) + RAD_W'(sq_reg[2]);
                root_next = '0;
                bit_next  = ROOT_START;
                if (grp_reg == GRP_LAST)
                begin
                    grp_next   = '0;
                    state_next = S_AVG_MUL;
                end
                else
                begin
                    grp_next   = grp_reg + 1'b1;
                    fresh_next = 1'b0;
                    state_next = S_SQRT;
                end
            end
            S_AVG_MUL:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    neg_next[k]  = msum_reg[k][SUM_W-1];
                    prod_next[k] = PROD_W'(abs_sum(msum_reg[k])) * PROD_W'(AVG_MUL);
                end
                state_next = S_CLASS;
            end
            S_CLASS:
            begin
                // An axis wins only when it is strictly closer to one g than both others.
                if (dev[0] < dev[1] && dev[0] < dev[2])
                begin
                    orient_next = (avg[0] > 0) ? ORIENT_POS_X : ORIENT_NEG_X;
                end
                else if (dev[1] < dev[0] && dev[1] < dev[2])
                begin
                    orient_next = (avg[1] > 0) ? ORIENT_POS_Y : ORIENT_NEG_Y;
                end
                else if (dev[2] < dev[0] && dev[2] < dev[1])
                begin
                    orient_next = (avg[2] > 0) ? ORIENT_POS_Z : ORIENT_NEG_Z;
                end
                else
                begin
                    orient_next = ORIENT_NONE;
                end
                fresh_next = 1'b1;
                for (int k = 0; k < 3; k++)
                begin
                    msum_next[k] = '0;
                end
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                // One result bit per cycle, restoring square root.
                if (bit_reg == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    if (rad_reg >= trial)
                    begin
                        rad_next  = rad_reg - trial;
                        root_next = (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_next = root_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        out_mean_next[k] = MEAN_W'(mean_reg[k]);
                    end
                    out_mag_next    = MAG_W'(root_reg);
                    out_orient_next = orient_reg;
                    out_fresh_next  = fresh_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign result.valid             = out_valid_reg;
    assign result.mean_x            = out_mean_reg[0];
    assign result.mean_y            = out_mean_reg[1];
    assign result.mean_z            = out_mean_reg[2];
    assign result.magnitude         = out_mag_reg;
    assign result.orientation       = out_orient_reg;
    assign result.orientation_fresh = out_fresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            job_reg        <= '0;
            grp_reg        <= '0;
            orient_reg     <= ORIENT_NONE;
            fresh_reg      <= 1'b0;
            rad_reg        <= '0;
            root_reg       <= '0;
            bit_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_mag_reg    <= '0;
            out_orient_reg <= ORIENT_NONE;
            out_fresh_reg  <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k]     <= '0;
                neg_reg[k]      <= 1'b0;
                sq_reg[k]       <= '0;
                mean_reg[k]     <= '0;
                msum_reg[k]     <= '0;
                out_mean_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            job_reg        <= job_next;
            grp_reg        <= grp_next;
            orient_reg     <= orient_next;
            fresh_reg      <= fresh_next;
            rad_reg        <= rad_next;
            root_reg       <= root_next;
            bit_reg        <= bit_next;
            out_valid_reg  <= out_valid_next;
            out_mag_reg    <= out_mag_next;
            out_orient_reg <= out_orient_next;
            out_fresh_reg  <= out_fresh_next;
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k]     <= prod_next[k];
                neg_reg[k]      <= neg_next[k];
                sq_reg[k]       <= sq_next[k];
                mean_reg[k]     <= mean_next[k];
                msum_reg[k]     <= msum_next[k];
                out_mean_reg[k] <= out_mean_next[k];
            end
        end
    end

endmodule

`default_nettype wire

### design/accel_average_orientation.sv
// Path: a group's result passes through the two front stages (offset add, then scaling), the
// group queue, then the back end; averaging and classification states are added when the
// orientation is recomputed. Throughput: one sample per cycle until the two-entry group
// queue fills; the back end runs one group at a time through a 13-step bit-serial square root.
// Reset: asynchronous, active low; clears all counters, sums and the held orientation, and
// sets sensitivity_high to 1 and all offsets to zero. No clearing pass is needed.
`default_nettype none

module accel_average_orientation
    import aao_pkg::*;
#(
    parameter int unsigned SAMPLES_PER_GROUP      = SPG_DEFAULT,
    parameter int unsigned GROUPS_PER_ORIENTATION = GPO_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    aao_sample_if.sink            sample,
    aao_result_if.source          result,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data
);

    group_job_t push_job;
    group_job_t pop_job;
    logic       job_push;
    logic       job_full;
    logic       job_pop;
    logic       job_empty;

    aao_front #(
        .SAMPLES_PER_GROUP (SAMPLES_PER_GROUP)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .push     (job_push),
        .push_job (push_job),
        .full     (job_full)
    );

    aao_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .full     (job_full),
        .pop      (job_pop),
        .pop_job  (pop_job),
        .empty    (job_empty)
    );

    aao_back #(
        .SAMPLES_PER_GROUP      (SAMPLES_PER_GROUP),
        .GROUPS_PER_ORIENTATION (GROUPS_PER_ORIENTATION)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .empty   (job_empty),
        .pop     (job_pop),
        .pop_job (pop_job),
        .result  (result)
    );

`ifndef SYNTH
    // A finished group must never be offered to a full queue.
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !job_full)
        else $error("group pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> !job_empty)
        else $error("group popped from an empty queue");

    // The input is held off only while the group queue is full.
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> job_full)
        else $error("sample input stalled with room in the group queue");
`endif

endmodule

`default_nettype wire
